// ===== hw/rtl/fsd_pkg.sv =====
// Shared types and constants for the force sensor smoothing and press detect block.
package fsd_pkg;

  localparam int LEVEL_BITS     = 12;
  localparam int PERCENT_BITS   = 7;
  localparam int PCT_PROD_BITS  = LEVEL_BITS + PERCENT_BITS;
  localparam int STEP_BITS      = 5;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [PERCENT_BITS-1:0] PERCENT_SCALE   = 7'd100;
  localparam logic [LEVEL_BITS-1:0]   THRESHOLD_RESET = 12'd50;
  localparam logic [STEP_BITS-1:0]    PCT_STEPS       = 5'(PERCENT_BITS);
  localparam int                      PCT_ALIGN       = PERCENT_BITS - 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BASELINE  = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_AVG,
    S_PRESS,
    S_PCT_GO,
    S_PCT_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [STEP_BITS-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// ===== hw/rtl/force_sensor_smoothing_press_detect.sv =====
// Top level of the force sensor smoothing and press detect block.
//
// One word on the input channel carries one converter sample; one word on the
// output channel carries smoothed level, pressure, pressed flag and percent of
// baseline. Each channel moves a word at an edge where valid is high and stall
// is low. Configuration is a plain write port: cfg_index 0 is baseline_level,
// 1 is press_threshold.
// A sample is read against the ring memory, the running total is updated, the
// window average is taken with a constant reciprocal multiply, and one
// restoring divider then runs 7 steps for the percentage, one bit per cycle.
// The result word is registered through states S_SUM, S_AVG, S_PRESS, S_PCT_GO,
// S_PCT_RUN and S_DONE; no new sample is taken until the block is idle again.
// in_stall is high while an item is in work.
// A finished word waits in the output register while the next sample is taken;
// if it is still stalled when the next result is ready, the block holds there.
// Reset clears the ring (through valid bits, no clearing pass), the running
// total, the ring position, the output valid, and sets the baseline to 0 and
// the threshold to 50.
module force_sensor_smoothing_press_detect import fsd_pkg::*; #(
  parameter int WINDOW_LENGTH = 8,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LEVEL_BITS-1:0]     smoothed_level,
  output logic [LEVEL_BITS-1:0]     pressure,
  output logic                      pressed,
  output logic [PERCENT_BITS-1:0]   percent_of_full,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LEVEL_BITS-1:0]     cfg_data
);

  localparam int POS_BITS   = $clog2(WINDOW_LENGTH);
  localparam int TOTAL_BITS = SAMPLE_BITS + POS_BITS;
  localparam int DIV_BITS   = PCT_PROD_BITS;
  localparam int QUOT_BITS  = PERCENT_BITS;
  localparam int EXT_BITS   = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
  // The average is the total times a rounded-up reciprocal of the window length;
  // the extra POS_BITS of scale keep the floor exact for every possible total.
  localparam int RECIP_SHIFT   = TOTAL_BITS + POS_BITS;
  localparam int RECIP_BITS    = TOTAL_BITS + 2;
  localparam int AVG_PROD_BITS = RECIP_SHIFT + SAMPLE_BITS;
  localparam logic [RECIP_BITS-1:0] AVG_RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));
  localparam logic [POS_BITS-1:0]  LAST_POS    = POS_BITS'(WINDOW_LENGTH - 1);

  state_t                   state, state_next;
  logic [POS_BITS-1:0]      pos;
  logic [TOTAL_BITS-1:0]    total;
  logic [LEVEL_BITS-1:0]    baseline_level;
  logic [LEVEL_BITS-1:0]    press_threshold;
  logic [SAMPLE_BITS-1:0]   sample_hold;
  logic [SAMPLE_BITS-1:0]   level;
  logic [LEVEL_BITS-1:0]    press_work;
  logic                     pressed_work;
  logic [PERCENT_BITS-1:0]  percent_work;
  logic [PERCENT_BITS-1:0]  quot_pct;

  logic                     accept;
  logic                     rd_en;
  logic                     ring_wr;
  logic                     load_out;
  logic [SAMPLE_BITS-1:0]   old_sample;
  logic [EXT_BITS-1:0]      level_ext;
  logic [EXT_BITS-1:0]      baseline_ext;
  logic [PCT_PROD_BITS-1:0] pct_prod;
  logic [AVG_PROD_BITS-1:0] avg_prod;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic [DIV_BITS-1:0]      div_dividend;
  logic [DIV_BITS-1:0]      div_divisor;
  logic [QUOT_BITS-1:0]     quotient;

  assign in_stall     = (state != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign level_ext    = EXT_BITS'(level);
  assign baseline_ext = EXT_BITS'(baseline_level);
  assign pct_prod     = PCT_PROD_BITS'(press_work) * PCT_PROD_BITS'(PERCENT_SCALE);
  assign quot_pct     = quotient[PERCENT_BITS-1:0];
  assign avg_prod     = AVG_PROD_BITS'(total) * AVG_PROD_BITS'(AVG_RECIP);

  fsd_ring #(
    .DEPTH (WINDOW_LENGTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (pos),
    .rd_data (old_sample),
    .wr_en   (ring_wr),
    .wr_addr (pos),
    .wr_data (sample_hold)
  );

  fsd_div #(
    .W  (DIV_BITS),
    .QW (QUOT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    rd_en        = 1'b0;
    ring_wr      = 1'b0;
    load_out     = 1'b0;
    div_req      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rd_en      = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        ring_wr    = 1'b1;
        state_next = S_AVG;
      end
      S_AVG: begin
        state_next = S_PRESS;
      end
      S_PRESS: begin
        state_next = S_PCT_GO;
      end
      S_PCT_GO: begin
        div_req.start = 1'b1;
        div_req.steps = PCT_STEPS;
        div_dividend  = pct_prod;
        // Pressure never exceeds the baseline, so seven quotient bits suffice.
        div_divisor   = DIV_BITS'(baseline_level) << PCT_ALIGN;
        state_next    = S_PCT_RUN;
      end
      S_PCT_RUN: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      total           <= '0;
      out_valid       <= 1'b0;
      baseline_level  <= '0;
      press_threshold <= THRESHOLD_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_BASELINE:  baseline_level  <= cfg_data;
          CFG_THRESHOLD: press_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (ring_wr) begin
        total <= total - TOTAL_BITS'(old_sample) + TOTAL_BITS'(sample_hold);
        pos   <= (pos == LAST_POS) ? '0 : pos + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_hold <= sample;
    end
    if (state == S_AVG) begin
      level <= avg_prod[AVG_PROD_BITS-1:RECIP_SHIFT];
    end
    if (state == S_PRESS) begin
      press_work <= (baseline_ext > level_ext) ? LEVEL_BITS'(baseline_ext - level_ext) : '0;
    end
    if (state == S_PCT_GO) begin
      pressed_work <= (press_work > press_threshold);
    end
    if (state == S_PCT_RUN && div_rsp.done) begin
      if (baseline_level == '0) begin
        percent_work <= '0;
      end else if (quot_pct > PERCENT_SCALE) begin
        percent_work <= PERCENT_SCALE;
      end else begin
        percent_work <= quot_pct;
      end
    end
    if (load_out) begin
      smoothed_level  <= level_ext[LEVEL_BITS-1:0];
      pressure        <= press_work;
      pressed         <= pressed_work;
      percent_of_full <= percent_work;
    end
  end

  a_idle_div_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while waiting for a sample");

  a_ring_after_accept: assert property (@(posedge clk) disable iff (rst)
    ring_wr |-> $past(accept))
    else $error("ring written without a sample taken");

  a_pressed_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pressed) |-> (pressure != '0))
    else $error("pressed flag with zero pressure");

  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (percent_of_full <= PERCENT_SCALE))
    else $error("percent above full scale");

endmodule

// ===== hw/rtl/fsd_ring.sv =====
// Sample ring memory with per-entry valid bits so unwritten entries read as zero.
module fsd_ring import fsd_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_raw;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

// ===== hw/rtl/fsd_div.sv =====
// Restoring divider, one quotient bit per cycle from a pre-aligned divisor.
module fsd_div import fsd_pkg::*; #(
  parameter int W  = 22,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  div_req_t      req,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  output div_rsp_t      rsp,
  output logic [QW-1:0] quotient
);

  logic [W-1:0]         rem;
  logic [W-1:0]         dv;
  logic [W:0]           diff;
  logic [STEP_BITS-1:0] cnt;

  // The top bit of the difference is the borrow: set when dv does not fit.
  assign diff = {1'b0, rem} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.busy <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        rsp.busy <= 1'b1;
        cnt      <= req.steps;
      end else if (rsp.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_BITS'(1)) begin
          rsp.busy <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= dividend;
      dv       <= divisor;
      quotient <= '0;
    end else if (rsp.busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
      end
      quotient <= {quotient[QW-2:0], ~diff[W]};
      dv       <= dv >> 1;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !rsp.busy)
    else $error("divider started while busy");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the force sensor smoothing and press detect block.
module testbench;
  import fsd_pkg::*;

  localparam int WINDOW      = 8;
  localparam int SAMPLE_W    = 12;
  localparam int LEVEL_MAX   = 4095;
  localparam int LATENCY     = 14;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]   level;
    logic [LEVEL_BITS-1:0]   pressure;
    logic                    pressed;
    logic [PERCENT_BITS-1:0] percent;
  } reading_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SAMPLE_W-1:0]     sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [LEVEL_BITS-1:0]   smoothed_level;
  logic [LEVEL_BITS-1:0]   pressure;
  logic                    pressed;
  logic [PERCENT_BITS-1:0] percent_of_full;
  logic                    cfg_write = 1'b0;
  cfg_index_t              cfg_index = CFG_BASELINE;
  logic [LEVEL_BITS-1:0]   cfg_data = '0;

  // Mirror of the block: sample window, write position, total and registers.
  logic [SAMPLE_W-1:0]   win_samples [WINDOW];
  logic [2:0]            win_pos = '0;
  logic [14:0]           win_total = '0;
  logic [LEVEL_BITS-1:0] base_cfg = '0;
  logic [LEVEL_BITS-1:0] thr_cfg = THRESHOLD_RESET;

  reading_t pending_readings[$];
  int       cycle_count = 0;
  int       error_count = 0;
  int       readings_checked = 0;
  int       samples_sent = 0;
  int       reg_writes = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       cur_base = 0;
  int       cur_thr = THRESHOLD_RESET;

  force_sensor_smoothing_press_detect #(
    .WINDOW_LENGTH(WINDOW),
    .SAMPLE_BITS  (SAMPLE_W)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .smoothed_level (smoothed_level),
    .pressure       (pressure),
    .pressed        (pressed),
    .percent_of_full(percent_of_full),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < WINDOW; i++) win_samples[i] = '0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // The receiver stalls at random; the rate is changed between phases.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Pushes one sample into the window and works out the reading it gives.
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] s);
    reading_t r;
    int       lvl, prs, pct;
    win_total = win_total - win_samples[win_pos] + s;
    win_samples[win_pos] = s;
    win_pos = (win_pos == WINDOW - 1) ? 3'd0 : win_pos + 3'd1;
    lvl = int'(win_total) / WINDOW;
    prs = (int'(base_cfg) > lvl) ? int'(base_cfg) - lvl : 0;
    if (base_cfg == 0) begin
      pct = 0;
    end else begin
      pct = (prs * 100) / int'(base_cfg);
      if (pct > 100) pct = 100;
    end
    r.level    = LEVEL_BITS'(lvl);
    r.pressure = LEVEL_BITS'(prs);
    r.pressed  = (prs > int'(thr_cfg));
    r.percent  = PERCENT_BITS'(pct);
    return r;
  endfunction

  // One process sees both channels and the register port, so the order of
  // events within a step does not matter.
  always @(posedge clk) begin
    reading_t want, got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{smoothed_level, pressure, pressed, percent_of_full};
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected word: level %0d pressure %0d pressed %0d percent %0d",
                   $time, got.level, got.pressure, got.pressed, got.percent);
          error_count++;
        end else begin
          want = pending_readings.pop_front();
          readings_checked++;
          if (got !== want) begin
            $display("%0t: mismatch: expected level %0d pressure %0d pressed %0d percent %0d",
                     $time, want.level, want.pressure, want.pressed, want.percent);
            $display("%0t:           actual   level %0d pressure %0d pressed %0d percent %0d",
                     $time, got.level, got.pressure, got.pressed, got.percent);
            error_count++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_BASELINE:  base_cfg = cfg_data;
          CFG_THRESHOLD: thr_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_readings.push_back(predict_reading(sample));
    end
  end

  // Called and returning at a falling edge; valid stays high until the word
  // is taken, and the caller's next action decides what it does next.
  task automatic send_word(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic drain_readings();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(input int base, input int thr);
    drain_readings();
    cfg_write <= 1'b1;
    cfg_index <= CFG_BASELINE;
    cfg_data  <= LEVEL_BITS'(base);
    @(negedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= LEVEL_BITS'(thr);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    cur_base = base;
    cur_thr  = thr;
    reg_writes += 2;
  endtask

  function automatic int pick_level();
    case ($urandom_range(5))
      0:       return 0;
      1:       return LEVEL_MAX;
      default: return $urandom_range(LEVEL_MAX);
    endcase
  endfunction

  // Reset registers: the baseline is zero, so pressure and percent stay zero.
  task automatic test_zero_baseline();
    send_word(12'hFFF);
    send_word(12'h000);
    send_word(12'hFFF);
  endtask

  // Full-scale baseline with a zero threshold and an all-zero window.
  task automatic test_full_scale();
    set_config(LEVEL_MAX, 0);
    repeat (8) send_word(12'h000);
  endtask

  // Level climbs far above a small baseline, so pressure clamps at zero.
  task automatic test_level_above_baseline();
    set_config(16, LEVEL_MAX);
    repeat (4) send_word(12'hFFF);
  endtask

  // Window now averages 2047; pressure of 500 against thresholds 500 and 499.
  task automatic test_threshold_edge();
    set_config(2547, 500);
    send_word(12'h000);
    set_config(2547, 499);
    send_word(12'h000);
  endtask

  // Samples settle around a target level for a stretch, with some words
  // drawn uniformly; registers change every few dozen words.
  task automatic test_random_phase(input int n_items, input int send_pct,
                                   input int recv_pct);
    int target, v;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 25 == 0) set_config(pick_level(), pick_level());
      if (k % 12 == 0) begin
        case ($urandom_range(3))
          0: target = $urandom_range(LEVEL_MAX);
          1: target = cur_base;
          2: target = cur_base - cur_thr;
          default: target = $urandom_range(1) ? LEVEL_MAX : 0;
        endcase
      end
      if ($urandom_range(3) == 0) begin
        v = $urandom_range(LEVEL_MAX);
      end else begin
        v = target + int'($urandom_range(127)) - 64;
        if (v < 0) v = 0;
        else if (v > LEVEL_MAX) v = LEVEL_MAX;
      end
      send_word(SAMPLE_W'(v));
    end
  endtask

  initial begin
    send_idle_pct  = 19;
    recv_stall_pct = 45;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_zero_baseline();
    test_full_scale();
    test_level_above_baseline();
    test_threshold_edge();
    test_random_phase(340, 19, 45);
    test_random_phase(330, 45, 19);
    test_random_phase(330, 0, 0);

    drain_readings();
    repeat (2 * LATENCY) @(negedge clk);
    $display("Sent %0d samples and checked %0d readings across %0d register writes,",
             samples_sent, readings_checked, reg_writes);
    $display("under three idle and stall mixes, including register extremes.");
    if (error_count == 0 && pending_readings.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
